[hw/rtl/dlts_pkg.sv]
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and constants of the delta list timer scheduler: result
// status codes, entry layout, read address selects and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dlts_pkg;

  // Default table depth and the most expiries reported by one tick.
  localparam int MAX_TIMERS_DEF = 16;
  localparam int MAX_RESULTS    = 16;

  // Field widths.
  localparam int ID_W    = 16;
  localparam int DELAY_W = 32;
  localparam int STAT_W  = 3;
  localparam int TICK_W  = 32;
  localparam int ENTRY_W = ID_W + DELAY_W;
  localparam int NRES_W  = $clog2(MAX_RESULTS + 1);

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_SET_HEAD  = 3'd0;
  localparam logic [STAT_W-1:0] ST_SET_LIST  = 3'd1;
  localparam logic [STAT_W-1:0] ST_REJ_ZERO  = 3'd2;
  localparam logic [STAT_W-1:0] ST_REJ_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_TICK_IDLE = 3'd4;
  localparam logic [STAT_W-1:0] ST_TICK_PEND = 3'd5;
  localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd6;

  // Input kinds.
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Read address selects of the entry memory.
  localparam int RSEL_W = 3;
  localparam logic [RSEL_W-1:0] RS_HEAD  = 3'd0; // head entry
  localparam logic [RSEL_W-1:0] RS_HEAD1 = 3'd1; // entry after the head
  localparam logic [RSEL_W-1:0] RS_POS1  = 3'd2; // entry after the walk position
  localparam logic [RSEL_W-1:0] RS_CNT1  = 3'd3; // last live entry
  localparam logic [RSEL_W-1:0] RS_SH2   = 3'd4; // next source of the shift
  localparam logic [RSEL_W-1:0] RS_EMIT  = 3'd5; // expired entry being reported

  typedef struct packed {
    logic                latch_in;
    logic                walk_init;
    logic                walk_step;
    logic                sh_init;
    logic                sh_step;
    logic                insert;
    logic                tick_inc;
    logic                tick_wr;
    logic                exp_init;
    logic                expire;
    logic                exp_done;
    logic                em_load;
    logic                res_load;
    logic                stat_we;
    logic [STAT_W-1:0]   stat_code;
    logic [RSEL_W-1:0]   rsel;
  } dlts_cmd_t;

  typedef struct packed {
    logic kind_tick;
    logic delay_zero;
    logic full;
    logic empty;
    logic walk_go;
    logic pos_lt_cnt;
    logic pos_zero;
    logic sh_last;
    logic dec_zero;
    logic exp_more;
    logic em_last;
    logic out_free;
  } dlts_stat_t;

endpackage

[hw/rtl/dlts_ram.sv]
// ----------------------------------------------------------------------------
// dlts_ram
// Generic simple dual port RAM: one write port, one read port with the read
// data registered. A read in the same cycle as a write to that address
// returns the old contents.
// ----------------------------------------------------------------------------
module dlts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/dlts_datapath.sv]
// ----------------------------------------------------------------------------
// dlts_datapath
// Entry memory kept as a circular buffer, walk and shift registers, tick
// counter, expiry bookkeeping and the output register.
// ----------------------------------------------------------------------------
module dlts_datapath #(
  parameter int MAX_TIMERS = dlts_pkg::MAX_TIMERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dlts_pkg::dlts_cmd_t               cmd,
  output dlts_pkg::dlts_stat_t              st,
  input  logic                              in_kind,
  input  logic [dlts_pkg::ID_W-1:0]         in_timer_id,
  input  logic [dlts_pkg::DELAY_W-1:0]      in_delay,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [dlts_pkg::STAT_W-1:0]       out_status,
  output logic [dlts_pkg::ID_W-1:0]         out_expired_id,
  output logic [dlts_pkg::DELAY_W-1:0]      out_head_remaining,
  output logic [dlts_pkg::TICK_W-1:0]       out_tick_total,
  output logic                              out_last
);

  localparam int AW = $clog2(MAX_TIMERS);
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int NW = dlts_pkg::NRES_W;
  localparam int OW = (CW > NW) ? CW : NW;
  localparam int SW = OW + 1;
  localparam int DW = dlts_pkg::DELAY_W;
  localparam int IW = dlts_pkg::ID_W;

  // Position inside the live list to memory address.
  function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
                                             input logic [OW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(MAX_TIMERS)) begin
      sum = sum - SW'(MAX_TIMERS);
    end
    return sum[AW-1:0];
  endfunction

  // Item and list registers.
  logic                       kind_r, kind_nxt;
  logic [IW-1:0]              id_r, id_nxt;
  logic [DW-1:0]              delay_r, delay_nxt;
  logic [AW-1:0]              head_r, head_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              pos_r, pos_nxt;
  logic [CW-1:0]              sh_r, sh_nxt;
  logic [DW-1:0]              rem_r, rem_nxt;
  logic [DW-1:0]              head_rem_r, head_rem_nxt;
  logic [dlts_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [AW-1:0]              exp_start_r, exp_start_nxt;
  logic [NW-1:0]              n_r, n_nxt;
  logic [NW-1:0]              k_r, k_nxt;
  logic [dlts_pkg::STAT_W-1:0] stat_r, stat_nxt;

  // Output register.
  logic                        ov_r, ov_nxt;
  logic [dlts_pkg::STAT_W-1:0] os_r, os_nxt;
  logic [IW-1:0]               oid_r, oid_nxt;
  logic [DW-1:0]               ohead_r, ohead_nxt;
  logic [dlts_pkg::TICK_W-1:0] otick_r, otick_nxt;
  logic                        olast_r, olast_nxt;

  // Memory ports.
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [dlts_pkg::ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [dlts_pkg::ENTRY_W-1:0] ram_rdata;
  logic [DW-1:0]                rdelta;
  logic [IW-1:0]                rid;
  logic [DW-1:0]                dec;
  logic [DW-1:0]                head_cur;
  logic                         out_free;

  dlts_ram #(
    .WIDTH (dlts_pkg::ENTRY_W),
    .DEPTH (MAX_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rdelta   = ram_rdata[DW-1:0];
  assign rid      = ram_rdata[dlts_pkg::ENTRY_W-1:DW];
  // A head delta that is already zero is not decremented.
  assign dec      = rdelta - DW'(rdelta != '0);
  assign head_cur = (cnt_r == '0) ? '0 : head_rem_r;
  assign out_free = !ov_r || !out_stall;

  // Read address.
  always_comb begin
    case (cmd.rsel)
      dlts_pkg::RS_HEAD1: ram_raddr = wrap_idx(head_r, OW'(1));
      dlts_pkg::RS_POS1:  ram_raddr = wrap_idx(head_r, OW'(pos_r) + OW'(1));
      dlts_pkg::RS_CNT1:  ram_raddr = wrap_idx(head_r,
                                        (cnt_r != '0) ? OW'(cnt_r) - OW'(1) : '0);
      dlts_pkg::RS_SH2:   ram_raddr = wrap_idx(head_r,
                                        (sh_r >= CW'(2)) ? OW'(sh_r) - OW'(2) : '0);
      dlts_pkg::RS_EMIT:  ram_raddr = wrap_idx(exp_start_r, OW'(k_r));
      default:            ram_raddr = head_r;
    endcase
  end

  // Write port: shift step, new entry or head write-back after a tick.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_wdata = {rid, dec};
    if (cmd.sh_step) begin
      ram_we    = 1'b1;
      ram_waddr = wrap_idx(head_r, OW'(sh_r));
      // The entry that follows the new one loses the new entry's delta.
      ram_wdata = {rid, rdelta - ((sh_r - CW'(1) == pos_r) ? rem_r : '0)};
    end else if (cmd.insert) begin
      ram_we    = 1'b1;
      ram_waddr = wrap_idx(head_r, OW'(pos_r));
      ram_wdata = {id_r, rem_r};
    end else if (cmd.tick_wr) begin
      ram_we    = 1'b1;
      ram_waddr = head_r;
      ram_wdata = {rid, dec};
    end
  end

  // Register next values.
  always_comb begin
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    delay_nxt     = delay_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    head_rem_nxt  = head_rem_r;
    tick_nxt      = tick_r;
    exp_start_nxt = exp_start_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    stat_nxt      = stat_r;

    if (cmd.latch_in) begin
      kind_nxt  = in_kind;
      id_nxt    = in_timer_id;
      delay_nxt = in_delay;
    end
    if (cmd.walk_init) begin
      pos_nxt = '0;
      rem_nxt = delay_r;
    end
    if (cmd.walk_step) begin
      pos_nxt = pos_r + CW'(1);
      rem_nxt = rem_r - rdelta;
    end
    if (cmd.sh_init) begin
      sh_nxt = cnt_r;
    end
    if (cmd.sh_step) begin
      sh_nxt = sh_r - CW'(1);
    end
    if (cmd.insert) begin
      cnt_nxt = cnt_r + CW'(1);
      if (pos_r == '0) begin
        head_rem_nxt = rem_r;
      end
    end
    if (cmd.tick_inc) begin
      tick_nxt = tick_r + dlts_pkg::TICK_W'(1);
    end
    if (cmd.tick_wr) begin
      head_rem_nxt = dec;
    end
    if (cmd.expire) begin
      cnt_nxt  = cnt_r - CW'(1);
      head_nxt = wrap_idx(head_r, OW'(1));
      n_nxt    = n_r + NW'(1);
    end
    if (cmd.exp_init) begin
      exp_start_nxt = head_r;
      n_nxt         = NW'(1);
    end
    if (cmd.exp_done) begin
      head_rem_nxt = (cnt_r != '0) ? rdelta : '0;
      k_nxt        = '0;
    end
    if (cmd.em_load) begin
      k_nxt = k_r + NW'(1);
    end
    if (cmd.stat_we) begin
      stat_nxt = cmd.stat_code;
    end
  end

  // Output register.
  always_comb begin
    ov_nxt    = ov_r && out_stall;
    os_nxt    = os_r;
    oid_nxt   = oid_r;
    ohead_nxt = ohead_r;
    otick_nxt = otick_r;
    olast_nxt = olast_r;
    if (cmd.res_load) begin
      ov_nxt    = 1'b1;
      os_nxt    = stat_r;
      oid_nxt   = (kind_r == dlts_pkg::KIND_TICK) ? '0 : id_r;
      ohead_nxt = head_cur;
      otick_nxt = tick_r;
      olast_nxt = 1'b1;
    end else if (cmd.em_load) begin
      ov_nxt    = 1'b1;
      os_nxt    = dlts_pkg::ST_EXPIRED;
      oid_nxt   = rid;
      ohead_nxt = head_cur;
      otick_nxt = tick_r;
      olast_nxt = st.em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      tick_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      tick_r <= tick_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    id_r        <= id_nxt;
    delay_r     <= delay_nxt;
    pos_r       <= pos_nxt;
    sh_r        <= sh_nxt;
    rem_r       <= rem_nxt;
    head_rem_r  <= head_rem_nxt;
    exp_start_r <= exp_start_nxt;
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    stat_r      <= stat_nxt;
    os_r        <= os_nxt;
    oid_r       <= oid_nxt;
    ohead_r     <= ohead_nxt;
    otick_r     <= otick_nxt;
    olast_r     <= olast_nxt;
  end

  // Status to the controller.
  always_comb begin
    st.kind_tick  = (kind_r == dlts_pkg::KIND_TICK);
    st.delay_zero = (delay_r == '0);
    st.full       = (cnt_r == CW'(MAX_TIMERS));
    st.empty      = (cnt_r == '0);
    st.pos_lt_cnt = (pos_r < cnt_r);
    st.walk_go    = (pos_r < cnt_r) && (rem_r >= rdelta);
    st.pos_zero   = (pos_r == '0);
    st.sh_last    = (sh_r - CW'(1) == pos_r);
    st.dec_zero   = (dec == '0);
    st.exp_more   = (cnt_r != '0) && (rdelta == '0) && (n_r < NW'(dlts_pkg::MAX_RESULTS));
    st.em_last    = (k_r + NW'(1) == n_r);
    st.out_free   = out_free;
  end

  assign out_valid          = ov_r;
  assign out_status         = os_r;
  assign out_expired_id     = oid_r;
  assign out_head_remaining = ohead_r;
  assign out_tick_total     = otick_r;
  assign out_last           = olast_r;

endmodule

[hw/rtl/dlts_ctrl.sv]
// ----------------------------------------------------------------------------
// dlts_ctrl
// Controller state machine: sequences the insertion walk, the tail shift,
// the tick with its expiry walk and the delivery of results.
// ----------------------------------------------------------------------------
module dlts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dlts_pkg::dlts_stat_t st,
  output dlts_pkg::dlts_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_WALK   = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_INSERT = 4'd4;
  localparam logic [3:0] S_TICK   = 4'd5;
  localparam logic [3:0] S_EXP    = 4'd6;
  localparam logic [3:0] S_EM_RD  = 4'd7;
  localparam logic [3:0] S_EM     = 4'd8;
  localparam logic [3:0] S_RES    = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rsel  = dlts_pkg::RS_HEAD;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        if (st.kind_tick) begin
          if (st.empty) begin
            cmd.stat_we   = 1'b1;
            cmd.stat_code = dlts_pkg::ST_TICK_IDLE;
            state_nxt     = S_RES;
          end else begin
            state_nxt = S_TICK;
          end
        end else if (st.delay_zero) begin
          cmd.stat_we   = 1'b1;
          cmd.stat_code = dlts_pkg::ST_REJ_ZERO;
          state_nxt     = S_RES;
        end else if (st.full) begin
          cmd.stat_we   = 1'b1;
          cmd.stat_code = dlts_pkg::ST_REJ_FULL;
          state_nxt     = S_RES;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        if (st.walk_go) begin
          cmd.walk_step = 1'b1;
          cmd.rsel      = dlts_pkg::RS_POS1;
        end else if (st.pos_lt_cnt) begin
          cmd.sh_init = 1'b1;
          cmd.rsel    = dlts_pkg::RS_CNT1;
          state_nxt   = S_SHIFT;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_SHIFT: begin
        cmd.sh_step = 1'b1;
        cmd.rsel    = dlts_pkg::RS_SH2;
        if (st.sh_last) begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert    = 1'b1;
        cmd.stat_we   = 1'b1;
        cmd.stat_code = st.pos_zero ? dlts_pkg::ST_SET_HEAD : dlts_pkg::ST_SET_LIST;
        state_nxt     = S_RES;
      end
      S_TICK: begin
        cmd.tick_inc = 1'b1;
        if (!st.dec_zero) begin
          cmd.tick_wr   = 1'b1;
          cmd.stat_we   = 1'b1;
          cmd.stat_code = dlts_pkg::ST_TICK_PEND;
          state_nxt     = S_RES;
        end else begin
          cmd.exp_init = 1'b1;
          cmd.expire   = 1'b1;
          cmd.rsel     = dlts_pkg::RS_HEAD1;
          state_nxt    = S_EXP;
        end
      end
      S_EXP: begin
        if (st.exp_more) begin
          cmd.expire = 1'b1;
          cmd.rsel   = dlts_pkg::RS_HEAD1;
        end else begin
          cmd.exp_done = 1'b1;
          state_nxt    = S_EM_RD;
        end
      end
      S_EM_RD: begin
        cmd.rsel  = dlts_pkg::RS_EMIT;
        state_nxt = S_EM;
      end
      S_EM: begin
        cmd.rsel = dlts_pkg::RS_EMIT;
        if (st.out_free) begin
          cmd.em_load = 1'b1;
          state_nxt   = st.em_last ? S_IDLE : S_EM_RD;
        end
      end
      S_RES: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/delta_list_timer_scheduler.sv]
// ----------------------------------------------------------------------------
// delta_list_timer_scheduler
// Timer queue kept as a delta list: each entry holds its delay relative to
// the entry before it, so the head holds the time left to the next expiry.
// ----------------------------------------------------------------------------
// Usage. The input channel takes one item at a time: a set (kind 0) with a
// timer id and a delay, or a tick (kind 1). in_stall stays high while an item
// is being worked on. Each set and each non-expiring tick gives exactly one
// result item; a tick that expires timers gives one result per expired timer,
// up to sixteen, in deadline order, with out_last marking the final one.
// Every result of an item carries the head delta and tick count as they
// stand after the whole item.
// A set first runs the insertion walk over the entries that it steps over,
// then the tail shift moves the entries behind it, the two summing to the
// live count. A rejected set or a tick on an empty list goes straight to
// its result. A tick that expires timers runs the expiry walk over them,
// then reads each expired entry from the entry memory before loading its
// result. The entry memory has a single read port. The output register lets
// the next item be accepted while a result waits. Reset clears the list, the
// tick counter and the output valid; the entry memory needs no clearing.
// When the receiver stalls, the result holds and the block waits before
// loading the next result.
// ----------------------------------------------------------------------------
module delta_list_timer_scheduler #(
  parameter int MAX_TIMERS = dlts_pkg::MAX_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [dlts_pkg::ID_W-1:0]     in_timer_id,
  input  logic [dlts_pkg::DELAY_W-1:0]  in_delay,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dlts_pkg::STAT_W-1:0]   out_status,
  output logic [dlts_pkg::ID_W-1:0]     out_expired_id,
  output logic [dlts_pkg::DELAY_W-1:0]  out_head_remaining,
  output logic [dlts_pkg::TICK_W-1:0]   out_tick_total,
  output logic                          out_last
);

  // Commands from the controller and status back from the datapath.
  dlts_pkg::dlts_cmd_t  cmd;
  dlts_pkg::dlts_stat_t st;

  // The controller only sequences; all list state lives in the datapath.
  dlts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the entry memory as a circular buffer so that
  // expiries only advance the head pointer; inserts shift the tail.
  dlts_datapath #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_kind            (in_kind),
    .in_timer_id        (in_timer_id),
    .in_delay           (in_delay),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_expired_id     (out_expired_id),
    .out_head_remaining (out_head_remaining),
    .out_tick_total     (out_tick_total),
    .out_last           (out_last)
  );

endmodule

[hw/rtl/dlts_checker.sv]
// ----------------------------------------------------------------------------
// dlts_checker
// Port level checks of the delta list timer scheduler, attached by bind.
// ----------------------------------------------------------------------------
module dlts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [dlts_pkg::STAT_W-1:0]   out_status,
  input logic [dlts_pkg::ID_W-1:0]     out_expired_id,
  input logic [dlts_pkg::DELAY_W-1:0]  out_head_remaining,
  input logic [dlts_pkg::TICK_W-1:0]   out_tick_total,
  input logic                          out_last
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_expired_id) && $stable(out_head_remaining) &&
    $stable(out_tick_total) && $stable(out_last))
    else $error("result changed while stalled");

  // An accepted item keeps the input busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not busy after accepting an item");

  // Only expiries come in groups; every other result ends its item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != dlts_pkg::ST_EXPIRED) |-> out_last)
    else $error("non-expiry result without last");

  // A tick on an empty list reports no head delay.
  a_idle_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dlts_pkg::ST_TICK_IDLE) |-> out_head_remaining == '0)
    else $error("idle tick with non-zero head delay");

endmodule

bind delta_list_timer_scheduler dlts_checker u_dlts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_expired_id     (out_expired_id),
  .out_head_remaining (out_head_remaining),
  .out_tick_total     (out_tick_total),
  .out_last           (out_last)
);
